@@ src/api_pkg.sv @@
// Shared types and constants for the aligned pair identity block.
`timescale 1ns / 1ps

package api_pkg;

    localparam int unsigned RES_W     = 8;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned PCT_W     = 15;
    localparam int unsigned PROD_W    = CNT_W + PCT_W;
    localparam int unsigned STEP_W    = 4;

    localparam logic [RES_W-1:0]  GAP_RESET = 8'd32;
    localparam logic [PCT_W-1:0]  PCT_SCALE = 15'd25600;
    localparam logic [STEP_W-1:0] DIV_STEPS = 4'd15;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] length;
        logic             seen;
    } api_sum_t;

    typedef enum logic [2:0] {
        ST_ACCUM = 3'b001,
        ST_DIV   = 3'b010,
        ST_LOAD  = 3'b100
    } api_state_t;

endpackage

@@ src/api_accum.sv @@
// Per-column accumulator of identical columns and the trimmed overlap span.
`timescale 1ns / 1ps

module api_accum
    import api_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = 65535
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [RES_W-1:0] gap_code,
    input  logic             col_valid,
    input  logic             col_last,
    input  logic [RES_W-1:0] res_a,
    input  logic [RES_W-1:0] res_b,
    output api_sum_t         sum
);

    localparam logic [CNT_W-1:0] COL_LIMIT =
        (MAX_COLUMNS < 65535) ? CNT_W'(MAX_COLUMNS) : {CNT_W{1'b1}};

    logic [CNT_W-1:0] index_reg, index_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] last_reg,  last_next;
    logic             seen_reg,  seen_next;
    logic             in_range;
    logic             both;

    always_comb begin
        in_range   = index_reg < COL_LIMIT;
        both       = in_range && (res_a != gap_code) && (res_b != gap_code);
        index_next = in_range ? index_reg + 1'b1 : index_reg;
        first_next = (both && !seen_reg) ? index_reg : first_reg;
        last_next  = both ? index_reg : last_reg;
        seen_next  = seen_reg || both;
        count_next = (both && (res_a == res_b)) ? count_reg + 1'b1 : count_reg;
        sum.count  = count_next;
        sum.length = last_next - first_next + 1'b1;
        sum.seen   = seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (col_valid && col_last)) begin
            index_reg <= '0;
            count_reg <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (col_valid) begin
            index_reg <= index_next;
            count_reg <= count_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

@@ src/api_div.sv @@
// Scaling multiplier and restoring divider stepped one quotient bit per cycle.
`timescale 1ns / 1ps

module api_div
    import api_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CNT_W-1:0] count,
    input  logic [CNT_W-1:0] length,
    output logic             done,
    output logic [PCT_W-1:0] quotient
);

    logic              mul_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [PCT_W-1:0]  quo_reg, quo_next;
    logic [PROD_W-1:0] product;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    always_comb begin
        product  = PROD_W'(count_reg) * PROD_W'(PCT_SCALE);
        trial    = {rem_reg, quo_reg[PCT_W-1]};
        diff     = trial - {1'b0, len_reg};
        fits     = trial >= {1'b0, len_reg};
        rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_next = {quo_reg[PCT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            mul_reg  <= 1'b1;
            step_reg <= '0;
        end else if (mul_reg) begin
            mul_reg  <= 1'b0;
            step_reg <= DIV_STEPS;
        end else if (step_reg != '0) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            count_reg <= count;
            len_reg   <= length;
        end else if (mul_reg) begin
            rem_reg <= product[PROD_W-1:PCT_W];
            quo_reg <= product[PCT_W-1:0];
        end else if (step_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = (step_reg == STEP_W'(1));
    assign quotient = quo_reg;

endmodule

@@ src/aligned_pair_identity.sv @@
// Top level of the pairwise alignment identity counter.
//
// Alignment columns arrive on the slave stream, one transfer per column.
// The final column of an alignment carries tlast; after it the block stops
// accepting columns while the percent identity is worked out by one shared
// divider that yields a quotient bit per cycle (no division is done when no
// column had both residues). A new alignment can begin in the same cycle
// that the result appears on the master stream. Throughput is one column
// per cycle within an alignment.
// The finished result sits in an output register, so column transfers of
// the next alignment continue while the receiver stalls; only a second
// result waits for the first to be taken. The gap code is written through
// the configuration port; the user must write it only while the block is
// idle, as the block itself does not enforce this. Reset clears all
// counters, drops the result valid and restores the gap code to the space
// character.
`timescale 1ns / 1ps

module aligned_pair_identity
    import api_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = 65535
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [RES_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // res_a, res_b
    input  logic             s_tlast,   // last_column
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // identity_q8, identical_count, aligned_length
    output logic             m_tuser    // no_overlap
);

    api_state_t       state_reg, state_next;
    logic [RES_W-1:0] gap_reg;
    api_sum_t         sum;
    logic             col_valid;
    logic             col_last;
    logic             div_start;
    logic             div_done;
    logic [PCT_W-1:0] quotient;
    logic [CNT_W-1:0] res_count_reg;
    logic [CNT_W-1:0] res_len_reg;
    logic             res_seen_reg;
    logic             out_free;
    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;
    logic             m_tuser_reg;

    assign s_tready  = (state_reg == ST_ACCUM);
    assign col_valid = s_tvalid && s_tready;
    assign col_last  = col_valid && s_tlast;
    assign div_start = col_last && sum.seen;
    assign out_free  = !m_tvalid_reg || m_tready;

    api_accum #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .gap_code (gap_reg),
        .col_valid(col_valid),
        .col_last (s_tlast),
        .res_a    (s_tdata[7:0]),
        .res_b    (s_tdata[15:8]),
        .sum      (sum)
    );

    api_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .count   (sum.count),
        .length  (sum.length),
        .done    (div_done),
        .quotient(quotient)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (col_last) begin
                    state_next = sum.seen ? ST_DIV : ST_LOAD;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACCUM;
            gap_reg      <= GAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                gap_reg <= cfg_wr_data;
            end
            if (state_reg == ST_LOAD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (col_last) begin
            res_count_reg <= sum.count;
            res_len_reg   <= sum.length;
            res_seen_reg  <= sum.seen;
        end
        if (state_reg == ST_LOAD && out_free) begin
            m_tdata_reg <= {1'b0,
                            res_seen_reg ? res_len_reg : {CNT_W{1'b0}},
                            res_seen_reg ? res_count_reg : {CNT_W{1'b0}},
                            res_seen_reg ? quotient : {PCT_W{1'b0}}};
            m_tuser_reg <= !res_seen_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    ap_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("Input still accepted after the last column of an alignment.");

    ap_no_overlap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[46:0] == 47'd0))
        else $error("Result without overlap carries non-zero fields.");

    ap_identity_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:0] <= PCT_SCALE && m_tdata[30:15] <= m_tdata[46:31]))
        else $error("Identity or identical count out of range.");

    ap_div_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("Divider finished outside the division phase.");

endmodule
